>>> rtl/indentation_layout_token_inserter_defines.svh
// ----------------------------------------------------------------------------
// Indentation layout token inserter - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDENTATION_LAYOUT_TOKEN_INSERTER_DEFINES_SVH
`define INDENTATION_LAYOUT_TOKEN_INSERTER_DEFINES_SVH

// same-cycle implication
`define ILTI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ILTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ilti_pkg.sv
// ----------------------------------------------------------------------------
// ilti_pkg
// Types and constants shared by the layout token inserter modules.
// ----------------------------------------------------------------------------
package ilti_pkg;

  localparam int CODE_W = 8;
  localparam int COL_W  = 12;

  typedef enum logic [2:0] {
    KIND_TOKEN = 3'd0,
    KIND_SEMI  = 3'd1,
    KIND_OPEN  = 3'd2,
    KIND_CLOSE = 3'd3,
    KIND_EOF   = 3'd4
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic  load_in;
    logic  emit;
    kind_t kind;
    logic  last;
    logic  set_base;
    logic  push;
    logic  pop;
    logic  set_ovf;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic eoi;
    logic nl;
    logic col_eq;
    logic col_gt;
    logic col_lt;
    logic above_base;
    logic full;
    logic out_free;
  } status_t;

endpackage

>>> rtl/ilti_if.sv
// ----------------------------------------------------------------------------
// ilti token and result channels
// Valid/ready channels; a transfer occurs when valid and ready are high.
// ----------------------------------------------------------------------------
interface ilti_token_if;
  logic                       valid;
  logic                       ready;
  logic [ilti_pkg::CODE_W-1:0] token_code;
  logic [ilti_pkg::COL_W-1:0]  column;
  logic                       new_line;
  logic                       end_of_input;

  modport source (output valid, token_code, column, new_line, end_of_input,
                  input ready);
  modport sink   (input valid, token_code, column, new_line, end_of_input,
                  output ready);
endinterface

interface ilti_result_if;
  logic                        valid;
  logic                        ready;
  ilti_pkg::kind_t             kind;
  logic [ilti_pkg::CODE_W-1:0] token_code_out;
  logic                        last;
  logic                        overflow;

  modport source (output valid, kind, token_code_out, last, overflow,
                  input ready);
  modport sink   (input valid, kind, token_code_out, last, overflow,
                  output ready);
endinterface

>>> rtl/ilti_datapath.sv
// ----------------------------------------------------------------------------
// ilti_datapath
// Input holding register, indentation column stack, output register.
// ----------------------------------------------------------------------------
module ilti_datapath #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ilti_pkg::cmd_t              cmd,
  output ilti_pkg::status_t           status,
  input  logic [ilti_pkg::CODE_W-1:0] in_code,
  input  logic [ilti_pkg::COL_W-1:0]  in_col,
  input  logic                        in_nl,
  input  logic                        in_eoi,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ilti_pkg::kind_t             out_kind,
  output logic [ilti_pkg::CODE_W-1:0] out_code,
  output logic                        out_last,
  output logic                        out_ovf
);
  import ilti_pkg::*;
  `include "indentation_layout_token_inserter_defines.svh"

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CODE_W-1:0] code;
  logic [COL_W-1:0]  col;
  logic              nl;
  logic              eoi;
  logic              ovf;

  logic [COL_W-1:0]  stack_mem [STACK_DEPTH];
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     rd_ptr;
  logic [COL_W-1:0]  top_col;
  logic [COL_W-1:0]  below_col;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      code <= in_code;
      col  <= in_col;
      nl   <= in_nl;
      eoi  <= in_eoi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
    end else if (cmd.load_in) begin
      ovf <= 1'b0;
    end else if (cmd.set_ovf) begin
      ovf <= 1'b1;
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.set_base) begin
      count_next = CW'(1);
    end else if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end
  end

  // entry just below the new top, read every cycle
  assign rd_ptr = count_next - CW'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_base) begin
      stack_mem[0] <= col;
    end else if (cmd.push) begin
      stack_mem[count[AW-1:0]] <= col;
    end
    below_col <= stack_mem[rd_ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.set_base || cmd.push) begin
      top_col <= col;
    end else if (cmd.pop) begin
      top_col <= below_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind <= cmd.kind;
      out_code <= (cmd.kind == KIND_TOKEN) ? code : '0;
      out_last <= cmd.last;
      out_ovf  <= ovf | cmd.set_ovf;
    end
  end

  always_comb begin
    status.eoi        = eoi;
    status.nl         = nl;
    status.col_eq     = (col == top_col);
    status.col_gt     = (col > top_col);
    status.col_lt     = (col < top_col);
    status.above_base = (count > CW'(1));
    status.full       = (count == CW'(STACK_DEPTH));
    status.out_free   = !out_valid || out_ready;
  end

  `ILTI_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(STACK_DEPTH), "stack count past depth")
  `ILTI_ASSERT_NOW(a_pop_base, cmd.pop, count > CW'(1), "pop of base column")
  `ILTI_ASSERT_NOW(a_push_room, cmd.push, (count != '0) && (count < CW'(STACK_DEPTH)), "bad push")
  `ILTI_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid || out_ready, "result overwritten")
  `ILTI_ASSERT_NEXT(a_pop_count, cmd.pop, count == $past(count) - CW'(1), "pop lost")

endmodule

>>> rtl/ilti_ctrl.sv
// ----------------------------------------------------------------------------
// ilti_ctrl
// Sequencer: layout phase, per-token emission steps, input handshake.
// ----------------------------------------------------------------------------
module ilti_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ilti_pkg::status_t status,
  output ilti_pkg::cmd_t    cmd
);
  import ilti_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DEDENT,
    S_CLOSE,
    S_TOKEN
  } state_t;

  typedef enum logic [1:0] {
    P_WAIT,
    P_RUN,
    P_DONE
  } phase_t;

  state_t state;
  state_t state_next;
  phase_t phase;
  phase_t phase_next;

  always_comb begin
    cmd        = '0;
    cmd.kind   = KIND_TOKEN;
    state_next = state;
    phase_next = phase;
    cmd.load_in = in_valid && in_ready;
    case (state)
      S_IDLE: begin
        if (cmd.load_in) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (phase == P_DONE) begin
            cmd.kind   = KIND_EOF;
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end else if (status.eoi && phase == P_WAIT) begin
            cmd.kind   = KIND_EOF;
            cmd.last   = 1'b1;
            phase_next = P_DONE;
            state_next = S_IDLE;
          end else if (status.eoi) begin
            cmd.kind   = KIND_SEMI;
            state_next = S_CLOSE;
          end else if (phase == P_WAIT) begin
            cmd.kind     = KIND_TOKEN;
            cmd.last     = 1'b1;
            cmd.set_base = 1'b1;
            phase_next   = P_RUN;
            state_next   = S_IDLE;
          end else if (!status.nl) begin
            cmd.kind   = KIND_TOKEN;
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end else if (status.col_eq) begin
            cmd.kind   = KIND_SEMI;
            state_next = S_TOKEN;
          end else if (status.col_gt) begin
            cmd.kind    = KIND_OPEN;
            cmd.push    = !status.full;
            cmd.set_ovf = status.full;
            state_next  = S_TOKEN;
          end else begin
            cmd.kind   = KIND_SEMI;
            state_next = S_DEDENT;
          end
        end
      end
      S_DEDENT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.above_base && status.col_lt) begin
            cmd.kind = KIND_CLOSE;
            cmd.pop  = 1'b1;
          end else begin
            cmd.kind   = KIND_TOKEN;
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_CLOSE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.above_base) begin
            cmd.kind = KIND_CLOSE;
            cmd.pop  = 1'b1;
          end else begin
            cmd.kind   = KIND_EOF;
            cmd.last   = 1'b1;
            phase_next = P_DONE;
            state_next = S_IDLE;
          end
        end
      end
      S_TOKEN: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_TOKEN;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= P_WAIT;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

>>> rtl/indentation_layout_token_inserter.sv
// ----------------------------------------------------------------------------
// indentation_layout_token_inserter
// Offside-rule layout: turns token indentation into semicolon and brace tokens.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  tokens    in   token_code, column, new_line, end_of_input
//  results   out  kind, token_code_out, last, overflow
//
//  One token per transfer: accept, then evaluate; no overlap between tokens.
//  Each result is one step of the sequencer; a dedent or end of input adds
//  one step, and one close brace, per column popped from the column stack.
//  Result register stalls the sequencer only while a result waits untaken.
//  Synchronous reset clears phase, stack count and result valid; sets input ready.
// ----------------------------------------------------------------------------
module indentation_layout_token_inserter #(
  parameter int STACK_DEPTH = 16
) (
  input logic          clk,
  input logic          rst,
  ilti_token_if.sink   tokens,
  ilti_result_if.source results
);
  import ilti_pkg::*;

  cmd_t    cmd;
  status_t status;

  ilti_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tokens.valid),
    .in_ready (tokens.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ilti_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_code   (tokens.token_code),
    .in_col    (tokens.column),
    .in_nl     (tokens.new_line),
    .in_eoi    (tokens.end_of_input),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_kind  (results.kind),
    .out_code  (results.token_code_out),
    .out_last  (results.last),
    .out_ovf   (results.overflow)
  );

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb - layout token inserter testbench
// Drives scanned tokens into the offside-rule inserter and checks every emitted
// layout result against a predictor of the indentation column stack. Both
// channels draw random gaps, and the result side holds off once for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
  import ilti_pkg::*;

  localparam int STACK_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 400;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 800000;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_RUN  = 2'd1,
    PH_DONE = 2'd2
  } layout_phase_t;

  typedef struct packed {
    kind_t             kind;
    logic [CODE_W-1:0] code;
    logic              last;
    logic              overflow;
  } layout_mark_t;

  class layout_tracker;
    layout_phase_t    phase;
    logic [COL_W-1:0] cols[STACK_DEPTH];
    int unsigned      depth_used;
    int unsigned      deepest;
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      overflow_marks;
    layout_mark_t     expected_marks[$];

    function new();
      phase          = PH_WAIT;
      depth_used     = 0;
      deepest        = 0;
      mismatches     = 0;
      checked        = 0;
      overflow_marks = 0;
    endfunction

    function layout_mark_t mark(kind_t k, logic [CODE_W-1:0] c);
      layout_mark_t m;
      m.kind     = k;
      m.code     = (k == KIND_TOKEN) ? c : '0;
      m.last     = 1'b0;
      m.overflow = 1'b0;
      return m;
    endfunction

    function int unsigned pending();
      return expected_marks.size();
    endfunction

    function void note_token(logic [CODE_W-1:0] code, logic [COL_W-1:0] col, logic nl,
                             logic eoi);
      layout_mark_t marks[$];
      logic         ovf;
      ovf = 1'b0;
      if (phase == PH_DONE) begin
        marks.push_back(mark(KIND_EOF, '0));
      end else if (eoi) begin
        if (phase == PH_RUN) begin
          marks.push_back(mark(KIND_SEMI, '0));
          while (depth_used > 1) begin
            marks.push_back(mark(KIND_CLOSE, '0));
            depth_used--;
          end
        end
        marks.push_back(mark(KIND_EOF, '0));
        phase = PH_DONE;
      end else if (phase == PH_WAIT) begin
        cols[0]    = col;
        depth_used = 1;
        phase      = PH_RUN;
        marks.push_back(mark(KIND_TOKEN, code));
      end else begin
        if (nl) begin
          if (col == cols[depth_used-1]) begin
            marks.push_back(mark(KIND_SEMI, '0));
          end else if (col > cols[depth_used-1]) begin
            marks.push_back(mark(KIND_OPEN, '0));
            if (depth_used < STACK_DEPTH) begin
              cols[depth_used] = col;
              depth_used++;
            end else begin
              ovf = 1'b1;
            end
          end else begin
            marks.push_back(mark(KIND_SEMI, '0));
            while (depth_used > 1 && col < cols[depth_used-1]) begin
              marks.push_back(mark(KIND_CLOSE, '0));
              depth_used--;
            end
          end
        end
        marks.push_back(mark(KIND_TOKEN, code));
      end
      if (depth_used > deepest) deepest = depth_used;
      foreach (marks[i]) begin
        marks[i].overflow = ovf;
        marks[i].last     = (i == marks.size() - 1);
        expected_marks.push_back(marks[i]);
      end
    endfunction

    function void check_result(kind_t k, logic [CODE_W-1:0] c, logic lst, logic ovf);
      layout_mark_t want;
      checked++;
      if (ovf === 1'b1) overflow_marks++;
      if (expected_marks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d code=%0h last=%0b ovf=%0b", k, c, lst, ovf);
        return;
      end
      want = expected_marks.pop_front();
      if (k !== want.kind || c !== want.code || lst !== want.last || ovf !== want.overflow)
      begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected kind=%0d code=%0h last=%0b ovf=%0b,",
                   want.kind, want.code, want.last, want.overflow);
          $display("          got kind=%0d code=%0h last=%0b ovf=%0b", k, c, lst, ovf);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  ilti_token_if  tok_if();
  ilti_result_if res_if();

  indentation_layout_token_inserter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .tokens(tok_if),
    .results(res_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  layout_tracker tracker = new();
  bit            sender_steady = 1'b0;
  int unsigned   hold_request  = 0;
  int unsigned   tokens_sent   = 0;

  initial begin
    #(LIMIT_CYCLES * 8);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_token(input logic [CODE_W-1:0] code, input logic [COL_W-1:0] col,
                            input logic nl, input logic eoi);
    int unsigned gap;
    gap = sender_steady ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap != 0) begin
      tok_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tok_if.valid        <= 1'b1;
    tok_if.token_code   <= code;
    tok_if.column       <= col;
    tok_if.new_line     <= nl;
    tok_if.end_of_input <= eoi;
    do @(posedge clk); while (!tok_if.ready);
    tracker.note_token(code, col, nl, eoi);
    tokens_sent++;
  endtask

  // mostly well-formed layout: same column, indents, dedents to stored columns
  task automatic send_layout_token();
    int unsigned pick;
    int unsigned idx;
    int          top;
    int          lo;
    int          hi;
    logic        nl;
    int          col;
    pick = $urandom_range(0, 99);
    top  = int'(tracker.cols[tracker.depth_used-1]);
    nl   = 1'b1;
    if (pick < 28) begin
      nl  = 1'b0;
      col = $urandom_range(0, 4095);
    end else if (pick < 46) begin
      col = top;
    end else if (pick < 72) begin
      col = top + $urandom_range(1, 200);
      if (col > 4095) col = 4095;
    end else if (pick < 90) begin
      idx = $urandom_range(0, tracker.depth_used - 1);
      col = int'(tracker.cols[idx]);
    end else if (pick < 96 && tracker.depth_used > 1) begin
      idx = $urandom_range(1, tracker.depth_used - 1);
      lo  = int'(tracker.cols[idx-1]) + 1;
      hi  = int'(tracker.cols[idx]) - 1;
      col = (lo <= hi) ? $urandom_range(lo, hi) : int'(tracker.cols[idx-1]);
    end else begin
      col = (tracker.cols[0] > 0) ? $urandom_range(0, int'(tracker.cols[0]) - 1) : 0;
    end
    send_token(CODE_W'($urandom_range(0, 255)), COL_W'(col), nl, 1'b0);
  endtask

  // result side
  initial begin
    int unsigned gap;
    bit          receiver_steady;
    receiver_steady = 1'b0;
    res_if.ready    = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 99) < 3) receiver_steady = !receiver_steady;
      if (hold_request != 0) begin
        gap          = hold_request;
        hold_request = 0;
      end else begin
        gap = receiver_steady ? 0 : $urandom_range(0, 10);
      end
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      tracker.check_result(res_if.kind, res_if.token_code_out, res_if.last, res_if.overflow);
      @(negedge clk);
    end
  end

  initial begin
    rst                 = 1'b1;
    tok_if.valid        = 1'b0;
    tok_if.token_code   = '0;
    tok_if.column       = '0;
    tok_if.new_line     = 1'b0;
    tok_if.end_of_input = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first token on a new line sets the base column
    send_token(8'h00, 12'd4, 1'b1, 1'b0);
    send_token(8'hFF, 12'd4095, 1'b0, 1'b0);
    send_token(8'h5A, 12'd4, 1'b1, 1'b0);
    // fill the column stack, then push once more onto a full stack
    for (int i = 1; i <= 16; i++)
      send_token(8'(i), (i == 16) ? 12'd4095 : 12'(4 + 200 * i), 1'b1, 1'b0);
    // dedent to an unmatched column, then below the base
    send_token(8'hA5, 12'd1000, 1'b1, 1'b0);
    send_token(8'h3C, 12'd0, 1'b1, 1'b0);
    send_token(8'hC3, 12'd0, 1'b1, 1'b0);
    send_token(8'h81, 12'd2000, 1'b1, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 3) sender_steady = !sender_steady;
      if (n == 150) begin
        sender_steady = 1'b1;
        hold_request  = LONG_HOLD;
      end
      if (n == 200) sender_steady = 1'b0;
      send_layout_token();
    end

    // end of input, then tokens after it
    send_token(CODE_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 4095)),
               1'($urandom_range(0, 1)), 1'b1);
    repeat (3)
      send_token(CODE_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 4095)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    @(negedge clk);
    tok_if.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d tokens and %0d layout results, %0d with overflow set.",
             tokens_sent, tracker.checked, tracker.overflow_marks);
    $display("Deepest column stack seen: %0d entries; mismatches: %0d.",
             tracker.deepest, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/ilti_pkg.sv
rtl/ilti_if.sv
rtl/ilti_datapath.sv
rtl/ilti_ctrl.sv
rtl/indentation_layout_token_inserter.sv
sim/tb.sv
